// ===== rtl/mexp_pkg.sv =====
// Shared constants, types and state encoding of the modular exponentiation unit.
package mexp_pkg;

  localparam int unsigned WordW = 32;
  localparam int unsigned ExpW  = 64;
  localparam int unsigned ProdW = 2 * WordW;
  // One fold of the high word (times five) onto the low word needs three extra bits; SumW gives four.
  localparam int unsigned SumW  = WordW + 4;

  // The prime is 2^32 - 5, so 2^32 is congruent to 5.
  localparam logic [WordW-1:0] Modulus = 32'hFFFF_FFFB;
  localparam logic [ExpW-1:0]  InvExp  = 64'h0000_0000_FFFF_FFF9;
  localparam logic [WordW-1:0] One     = 32'd1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ISSUE,
    ST_MUL,
    ST_WAIT,
    ST_DONE
  } mexp_state_e;

  typedef enum logic {
    OP_SQR,
    OP_ACC
  } mexp_op_e;

  // Control that travels alongside an operand pair through the multiplier.
  typedef struct packed {
    logic     vld;
    mexp_op_e op;
    logic     last;
  } mexp_ctl_t;

endpackage

// ===== rtl/modular_exponentiation_prime32_unit.sv =====
// Top level: right-to-left square-and-multiply modulo 2^32 - 5 on one shared multiplier.
//
//   channel   ports                                  transfer when
//   -------   ------------------------------------   --------------------------
//   command   start_i, busy_o, cmd_i, base_i,        start_i high, busy_o low
//             exponent_i
//   result    done_o, result_o                        done_o high (one cycle)
//
// Steps: with L the position of the highest set exponent bit plus one (0 for
// a zero exponent) and K the number of set bits, a command runs L
// power-of-two steps and K accumulates while busy_o stays high; each step
// squares through the two-stage multiplier and a set bit adds one accumulate,
// issued right behind the square. The inverse command uses exponent P - 2
// (32 bits, 30 set).
// Reset clears the sequencer to idle; operand registers hold no reset value.
// The receiver cannot stall: the result is valid in the cycle of done_o and holds until the next command is taken.
module modular_exponentiation_prime32_unit (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  output logic                        busy_o,
  input  logic                        cmd_i,
  input  logic [mexp_pkg::WordW-1:0]  base_i,
  input  logic [mexp_pkg::ExpW-1:0]   exponent_i,
  output logic                        done_o,
  output logic [mexp_pkg::WordW-1:0]  result_o
);
  import mexp_pkg::*;

  mexp_state_e      state_q, state_d;
  logic [WordW-1:0] base_q, base_d;
  logic [WordW-1:0] acc_q, acc_d;
  logic [ExpW-1:0]  exp_q, exp_d;

  mexp_ctl_t        req, rsp;
  logic [WordW-1:0] op_a, op_b, mul_res;

  mexp_mulmod u_mulmod (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .req_i  (req),
    .op_a_i (op_a),
    .op_b_i (op_b),
    .rsp_o  (rsp),
    .res_o  (mul_res)
  );

  // Next state: one exponent bit per trip through ISSUE, finish once the
  // remaining exponent is zero.
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (start_i) state_d = ST_ISSUE;
      end
      ST_ISSUE: begin
        if (exp_q == '0) begin
          state_d = ST_DONE;
        end else if (exp_q[0]) begin
          state_d = ST_MUL;
        end else begin
          state_d = ST_WAIT;
        end
      end
      ST_MUL: begin
        state_d = ST_WAIT;
      end
      ST_WAIT: begin
        // Advance once the last operation of this bit returns.
        if (rsp.vld && rsp.last) state_d = ST_ISSUE;
      end
      ST_DONE: begin
        state_d = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Outputs and multiplier issue.
  always_comb begin
    req    = '0;
    op_a   = base_q;
    op_b   = base_q;
    busy_o = 1'b1;
    done_o = 1'b0;
    case (state_q)
      ST_IDLE: begin
        busy_o = 1'b0;
      end
      ST_ISSUE: begin
        // Square the running base; it is the bit's last op when the bit is clear.
        if (exp_q != '0) begin
          req.vld  = 1'b1;
          req.op   = OP_SQR;
          req.last = ~exp_q[0];
        end
      end
      ST_MUL: begin
        // Accumulate with the base as it stood before this bit's square.
        req.vld  = 1'b1;
        req.op   = OP_ACC;
        req.last = 1'b1;
        op_a     = acc_q;
      end
      ST_WAIT: begin
        req = '0;
      end
      ST_DONE: begin
        done_o = 1'b1;
      end
      default: begin
        busy_o = 1'b1;
      end
    endcase
  end

  assign result_o = acc_q;

  // Operand registers: load on a command transfer, write back multiplier results.
  always_comb begin
    base_d = base_q;
    acc_d  = acc_q;
    exp_d  = exp_q;
    if (state_q == ST_IDLE) begin
      if (start_i) begin
        base_d = base_i;
        acc_d  = One;
        exp_d  = cmd_i ? InvExp : exponent_i;
      end
    end else if (rsp.vld) begin
      if (rsp.op == OP_SQR) begin
        base_d = mul_res;
      end else begin
        acc_d = mul_res;
      end
      // Drop the consumed exponent bit.
      if (rsp.last) exp_d = exp_q >> 1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i) begin
    base_q <= base_d;
    acc_q  <= acc_d;
    exp_q  <= exp_d;
  end

endmodule

// ===== rtl/mexp_mulmod.sv =====
// Two-stage pipelined 32x32 multiplier with reduction modulo 2^32 - 5.
module mexp_mulmod (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  mexp_pkg::mexp_ctl_t       req_i,
  input  logic [mexp_pkg::WordW-1:0] op_a_i,
  input  logic [mexp_pkg::WordW-1:0] op_b_i,
  output mexp_pkg::mexp_ctl_t       rsp_o,
  output logic [mexp_pkg::WordW-1:0] res_o
);
  import mexp_pkg::*;

  mexp_ctl_t        ctl1_q, ctl2_q;
  logic [ProdW-1:0] prod_q;
  logic [SumW-1:0]  sum_d, sum_q;
  logic [WordW:0]   fold2;
  logic [WordW:0]   diff;

  // Fold the high word: hi * 2^32 == hi * 5 (mod P).
  assign sum_d = {4'd0, prod_q[WordW-1:0]}
               + {2'd0, prod_q[ProdW-1:WordW], 2'd0}
               + {4'd0, prod_q[ProdW-1:WordW]};

  // Second fold leaves a value below 2P; one conditional subtract finishes.
  assign fold2 = {1'b0, sum_q[WordW-1:0]}
               + {{(WordW-5){1'b0}}, sum_q[SumW-1:WordW], 2'd0}
               + {{(WordW-3){1'b0}}, sum_q[SumW-1:WordW]};
  assign diff  = fold2 - {1'b0, Modulus};
  assign res_o = (fold2 >= {1'b0, Modulus}) ? diff[WordW-1:0] : fold2[WordW-1:0];
  assign rsp_o = ctl2_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ctl1_q <= '0;
      ctl2_q <= '0;
    end else begin
      ctl1_q <= req_i;
      ctl2_q <= ctl1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    prod_q <= ProdW'(op_a_i) * ProdW'(op_b_i);
    sum_q  <= sum_d;
  end

endmodule
